// File: rtl/elevator_scan_scheduler_defines.svh
// ----------------------------------------------------------------------------
// Elevator scan scheduler assertion macros
// Shared macros for concurrent checks on the scheduler logic.
// ----------------------------------------------------------------------------
`ifndef ELEVATOR_SCAN_SCHEDULER_DEFINES_SVH
`define ELEVATOR_SCAN_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ESS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// Next-cycle implication, disabled during reset.
`define ESS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

// File: rtl/ess_pkg.sv
// ----------------------------------------------------------------------------
// Elevator scan scheduler package
// Types, codes and fixed widths shared by the scheduler modules.
// ----------------------------------------------------------------------------
package ess_pkg;

    // Fixed field widths.
    localparam int FLOOR_W = 6;
    localparam int KIND_W  = 2;
    localparam int CAR_W   = 7;   // internal car floor, never above 63
    localparam int TOP_W   = 7;   // top floor index, the floor count register is 7 bits
    localparam int ARITH_W = 10;  // cycle index and distance arithmetic
    localparam int WGT_W   = 11;  // request weight

    // Largest number of floors served, and the move limit of the weight search.
    localparam int MAX_FLOORS = 64;
    localparam int WEIGHT_CAP = 4 * MAX_FLOORS + 8;

    // Direction codes.
    localparam logic [1:0] DIR_IDLE = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DN   = 2'd2;

    // Motion phase codes.
    localparam logic [1:0] PH_STAT    = 2'd0;
    localparam logic [1:0] PH_BETWEEN = 2'd1;
    localparam logic [1:0] PH_PASSING = 2'd2;

    // Request kinds.
    localparam logic [1:0] KIND_UP   = 2'd0;
    localparam logic [1:0] KIND_DOWN = 2'd1;
    localparam logic [1:0] KIND_DROP = 2'd2;

    // Input modes.
    localparam logic MODE_TICK    = 1'b0;
    localparam logic MODE_ENQUEUE = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FLOOR_COUNT = 2'd0;
    localparam logic [1:0] CFG_STAT_TICKS  = 2'd1;
    localparam logic [1:0] CFG_BTWN_TICKS  = 2'd2;
    localparam logic [1:0] CFG_PASS_TICKS  = 2'd3;

    // One queued request.
    typedef struct packed {
        logic [FLOOR_W-1:0] floor;
        logic [KIND_W-1:0]  kind;
    } entry_t;

    // Operation applied to every cell of the queue chain.
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_SHIFT  = 2'd1,
        CELL_INSERT = 2'd2
    } cell_op_t;

    // Car state seen by the weight unit.
    typedef struct packed {
        logic [CAR_W-1:0] floor;
        logic [1:0]       heading;
        logic [1:0]       phase;
        logic [TOP_W-1:0] top;
    } car_t;

endpackage

// File: rtl/ess_cell.sv
// ----------------------------------------------------------------------------
// Queue cell
// Holds one queue entry; shifts toward the head or opens a slot for insert.
// ----------------------------------------------------------------------------
module ess_cell
    import ess_pkg::*;
#(
    parameter int IDX_W = 6,
    parameter int POS   = 0
)
(
    input  logic             clk,
    input  cell_op_t         op,
    input  logic [IDX_W-1:0] ins_idx,
    input  entry_t           new_entry,
    input  entry_t           left_entry,
    input  entry_t           right_entry,
    output entry_t           entry
);

    entry_t entry_reg;
    entry_t entry_next;

    // Select the next content of this cell.
    always_comb
    begin
        entry_next = entry_reg;
        unique case (op)
            CELL_HOLD:
            begin
                entry_next = entry_reg;
            end
            CELL_SHIFT:
            begin
                entry_next = right_entry;
            end
            CELL_INSERT:
            begin
                if (ins_idx == IDX_W'(POS))
                begin
                    entry_next = new_entry;
                end
                else if (ins_idx < IDX_W'(POS))
                begin
                    entry_next = left_entry;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // Entry storage carries no reset.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// File: rtl/ess_weight.sv
// ----------------------------------------------------------------------------
// Request weight unit
// Computes twice the scan travel distance to a floor, plus one for drop-off.
// ----------------------------------------------------------------------------
module ess_weight
    import ess_pkg::*;
(
    input  logic [FLOOR_W-1:0] floor,
    input  logic [KIND_W-1:0]  kind,
    input  car_t               car,
    output logic [WGT_W-1:0]   weight
);

    logic [CAR_W-1:0]   f_ext;
    logic [1:0]         want;
    logic [1:0]         sd;
    logic               at_rest;
    logic               above;
    logic               far;
    logic [ARITH_W-1:0] top_x;
    logic [ARITH_W-1:0] cyc_len;
    logic [ARITH_W-1:0] t_idx;
    logic [ARITH_W-1:0] s_idx;
    logic [ARITH_W-1:0] m_raw;
    logic [ARITH_W-1:0] m_mod;
    logic [ARITH_W-1:0] pre;
    logic [ARITH_W-1:0] far_moves;
    logic [ARITH_W-1:0] span;

    assign f_ext   = CAR_W'(floor);
    assign top_x   = ARITH_W'(car.top);
    assign cyc_len = (top_x << 1) + ARITH_W'(2);
    assign at_rest = (f_ext == car.floor) && (car.phase == PH_STAT);
    assign above   = car.floor > CAR_W'(car.top);
    assign far     = f_ext > CAR_W'(car.top);

    // Direction the request needs and the direction the car starts in.
    always_comb
    begin
        priority if (kind == KIND_UP)
            want = DIR_UP;
        else if (kind == KIND_DOWN)
            want = DIR_DN;
        else if (f_ext > car.floor)
            want = DIR_UP;
        else if (f_ext < car.floor)
            want = DIR_DN;
        else
            want = (car.heading == DIR_UP) ? DIR_DN : DIR_UP;

        if (car.heading == DIR_IDLE)
            sd = (f_ext > car.floor) ? DIR_UP : DIR_DN;
        else
            sd = car.heading;
    end

    // Positions on the up-bounce-down-bounce cycle; a car above the top joins at
    // the downward top position.
    assign t_idx = (want == DIR_UP) ? ARITH_W'(floor)
                                    : (top_x << 1) + ARITH_W'(1) - ARITH_W'(floor);
    always_comb
    begin
        if (above)
            s_idx = top_x + ARITH_W'(1);
        else if (sd == DIR_UP)
            s_idx = ARITH_W'(car.floor);
        else
            s_idx = (top_x << 1) + ARITH_W'(1) - ARITH_W'(car.floor);
    end

    // Forward distance around the cycle.
    assign m_raw = t_idx + cyc_len - s_idx;
    assign m_mod = (m_raw >= cyc_len) ? (m_raw - cyc_len) : m_raw;
    assign pre   = ARITH_W'(car.floor) - top_x + ((sd == DIR_UP) ? ARITH_W'(1) : ARITH_W'(0));

    // A floor above the top is met only on a downward need, by a car above it heading
    // down or at or above it heading up; otherwise the search gives up at the move limit.
    always_comb
    begin
        if (want == DIR_DN && sd == DIR_DN && f_ext < car.floor)
            far_moves = ARITH_W'(car.floor) - ARITH_W'(floor);
        else if (want == DIR_DN && sd == DIR_UP && f_ext <= car.floor)
            far_moves = ARITH_W'(car.floor) - ARITH_W'(floor) + ARITH_W'(1);
        else
            far_moves = ARITH_W'(WEIGHT_CAP);
    end

    always_comb
    begin
        if (far)
            span = far_moves;
        else if (above)
            span = pre + m_mod;
        else if (m_mod == '0)
            span = cyc_len;
        else
            span = m_mod;
    end

    assign weight = at_rest ? WGT_W'(kind == KIND_DROP)
                            : ({WGT_W'(span)} << 1) + WGT_W'(kind == KIND_DROP);

endmodule

// File: rtl/elevator_scan_scheduler.sv
// ----------------------------------------------------------------------------
// Elevator scan scheduler
// Single-car scan scheduler with a sorted request queue held in a cell chain.
// ----------------------------------------------------------------------------
// A tick word passes from the tick state to the finish state, by way of the pop
// state when the car stops at a requested floor with matching head entries; an
// enqueue word that is rejected up front goes from the weight state straight to
// the finish state; for any other the queue chain rotates once through all
// QUEUE_DEPTH cells so the single weight unit can score each entry at the head
// in turn. One result word is produced per input word and is held in an output
// register until taken; the block returns to idle, ready for the next word, as
// that register is loaded.
module elevator_scan_scheduler
    import ess_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               mode,
    input  logic [FLOOR_W-1:0] floor,
    input  logic [KIND_W-1:0]  request_kind,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               accepted,
    output logic [5:0]         car_floor,
    output logic [1:0]         motion_state,
    output logic [1:0]         travel_direction,
    output logic [5:0]         queued_count
);

`include "elevator_scan_scheduler_defines.svh"

    localparam int LW = $clog2(QUEUE_DEPTH + 1);
    localparam int KW = $clog2(QUEUE_DEPTH);
    localparam int EW = 9;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_TICK  = 7'b0000010,
        ST_POP   = 7'b0000100,
        ST_WCALC = 7'b0001000,
        ST_SCAN  = 7'b0010000,
        ST_INS   = 7'b0100000,
        ST_FIN   = 7'b1000000
    } state_t;

    state_t            st_reg, st_next;
    logic [6:0]        fc_reg;
    logic [7:0]        stat_t_reg, btwn_t_reg, pass_t_reg;
    logic [LW-1:0]     len_reg, len_next;
    logic [CAR_W-1:0]  cur_reg, cur_next;
    logic [1:0]        head_reg, head_next;
    logic [1:0]        phase_reg, phase_next;
    logic [7:0]        prog_reg, prog_next;
    logic              mode_reg;
    entry_t            req_reg;
    logic              acc_reg, acc_next;
    logic [WGT_W-1:0]  w_reg, w_next;
    logic [KW-1:0]     k_reg, k_next;
    logic              found_reg, found_next;
    logic              dup_reg, dup_next;
    logic [LW-1:0]     ins_reg, ins_next;
    logic              out_valid_reg;
    logic              out_acc_reg;
    logic [5:0]        out_floor_reg, out_cnt_reg;
    logic [1:0]        out_phase_reg, out_dir_reg;

    cell_op_t          op;
    logic [LW-1:0]     op_idx;
    entry_t            cells [QUEUE_DEPTH];
    entry_t            head;
    entry_t            wsel;
    car_t              car;
    logic [WGT_W-1:0]  wgt;
    logic [EW-1:0]     eff;
    logic [TOP_W-1:0]  top;
    logic [7:0]        plen;
    logic              head_here;
    logic              out_free;

    // Effective floor count and top floor index.
    always_comb
    begin
        priority if (EW'(fc_reg) < EW'(2))
            eff = EW'(2);
        else if (EW'(fc_reg) > EW'(MAX_FLOORS))
            eff = EW'(MAX_FLOORS);
        else
            eff = EW'(fc_reg);
    end
    assign top = TOP_W'(eff - EW'(1));

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg     <= 7'd16;
            stat_t_reg <= 8'd4;
            btwn_t_reg <= 8'd4;
            pass_t_reg <= 8'd2;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_FLOOR_COUNT: fc_reg     <= cfg_data[6:0];
                CFG_STAT_TICKS:  stat_t_reg <= cfg_data;
                CFG_BTWN_TICKS:  btwn_t_reg <= cfg_data;
                CFG_PASS_TICKS:  pass_t_reg <= cfg_data;
                default:         fc_reg     <= fc_reg;
            endcase
        end
    end

    // Queue chain; the last cell takes the head so a full pass restores order.
    assign head = cells[0];
    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            ess_cell #(
                .IDX_W (LW),
                .POS   (gi)
            ) u_cell (
                .clk         (clk),
                .op          (op),
                .ins_idx     (op_idx),
                .new_entry   (req_reg),
                .left_entry  (cells[(gi == 0) ? 0 : gi - 1]),
                .right_entry (cells[(gi == QUEUE_DEPTH - 1) ? 0 : gi + 1]),
                .entry       (cells[gi])
            );
        end
    endgenerate

    // Weight unit, shared between the new request and the head entry.
    assign car.floor   = cur_reg;
    assign car.heading = head_reg;
    assign car.phase   = phase_reg;
    assign car.top     = top;
    assign wsel        = (st_reg == ST_SCAN) ? head : req_reg;

    ess_weight u_weight (
        .floor  (wsel.floor),
        .kind   (wsel.kind),
        .car    (car),
        .weight (wgt)
    );

    assign head_here = (len_reg != '0) && (CAR_W'(head.floor) == cur_reg);
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (st_reg == ST_IDLE);

    // Duration of the current phase; the unused code times as stationary.
    always_comb
    begin
        unique case (phase_reg)
            PH_BETWEEN: plen = btwn_t_reg;
            PH_PASSING: plen = pass_t_reg;
            default:    plen = stat_t_reg;
        endcase
    end

    // Sequencer.
    always_comb
    begin
        st_next    = st_reg;
        len_next   = len_reg;
        cur_next   = cur_reg;
        head_next  = head_reg;
        phase_next = phase_reg;
        prog_next  = prog_reg;
        acc_next   = acc_reg;
        w_next     = w_reg;
        k_next     = k_reg;
        found_next = found_reg;
        dup_next   = dup_reg;
        ins_next   = ins_reg;
        op         = CELL_HOLD;
        op_idx     = ins_reg;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    acc_next = 1'b0;
                    st_next  = (mode == MODE_ENQUEUE) ? ST_WCALC : ST_TICK;
                end
            end
            ST_TICK:
            begin
                st_next   = ST_FIN;
                prog_next = prog_reg + 8'd1;
                if (prog_reg == plen)
                begin
                    prog_next = 8'd1;
                    unique case (phase_reg)
                        PH_BETWEEN:
                        begin
                            phase_next = PH_STAT;
                            if (!((len_reg == '0) ||
                                  (head_reg != DIR_UP && head_reg != DIR_DN) ||
                                  (head_reg == DIR_DN && cur_reg == '0) ||
                                  (head_reg == DIR_UP && cur_reg >= CAR_W'(top))))
                            begin
                                cur_next = (head_reg == DIR_UP) ? cur_reg + CAR_W'(1)
                                                                : cur_reg - CAR_W'(1);
                                if (CAR_W'(head.floor) != cur_next)
                                    phase_next = PH_PASSING;
                            end
                        end
                        PH_PASSING:
                        begin
                            phase_next = PH_BETWEEN;
                        end
                        default:
                        begin
                            phase_next = PH_STAT;
                            if (len_reg == '0)
                                head_next = DIR_IDLE;
                            else if (head_here)
                                st_next = ST_POP;
                            else
                            begin
                                head_next  = (CAR_W'(head.floor) > cur_reg) ? DIR_UP
                                                                            : DIR_DN;
                                phase_next = PH_BETWEEN;
                            end
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                // Pop head entries one a cycle while they match the car floor.
                if (head_here)
                begin
                    op       = CELL_SHIFT;
                    len_next = len_reg - LW'(1);
                end
                else
                begin
                    st_next = ST_FIN;
                end
            end
            ST_WCALC:
            begin
                if (req_reg.kind > KIND_DROP || EW'(req_reg.floor) >= eff ||
                    len_reg >= LW'(QUEUE_DEPTH))
                begin
                    st_next = ST_FIN;
                end
                else
                begin
                    w_next     = wgt;
                    k_next     = '0;
                    found_next = 1'b0;
                    dup_next   = 1'b0;
                    st_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // Rotate the chain once, scoring each live entry at the head.
                op     = CELL_SHIFT;
                k_next = k_reg + KW'(1);
                if (!found_reg && (LW'(k_reg) < len_reg) && (w_reg <= wgt))
                begin
                    found_next = 1'b1;
                    dup_next   = (w_reg == wgt);
                    ins_next   = LW'(k_reg);
                end
                if (k_reg == KW'(QUEUE_DEPTH - 1))
                    st_next = ST_INS;
            end
            ST_INS:
            begin
                st_next = ST_FIN;
                if (!(found_reg && dup_reg))
                begin
                    op       = CELL_INSERT;
                    op_idx   = found_reg ? ins_reg : len_reg;
                    len_next = len_reg + LW'(1);
                    acc_next = 1'b1;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                    st_next = ST_IDLE;
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    // Control and car state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_IDLE;
            len_reg   <= '0;
            cur_reg   <= '0;
            head_reg  <= DIR_IDLE;
            phase_reg <= PH_STAT;
            prog_reg  <= '0;
            acc_reg   <= 1'b0;
            k_reg     <= '0;
            found_reg <= 1'b0;
            dup_reg   <= 1'b0;
            ins_reg   <= '0;
        end
        else
        begin
            st_reg    <= st_next;
            len_reg   <= len_next;
            cur_reg   <= cur_next;
            head_reg  <= head_next;
            phase_reg <= phase_next;
            prog_reg  <= prog_next;
            acc_reg   <= acc_next;
            k_reg     <= k_next;
            found_reg <= found_next;
            dup_reg   <= dup_next;
            ins_reg   <= ins_next;
        end
    end

    // Request and weight payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mode_reg      <= mode;
            req_reg.floor <= floor;
            req_reg.kind  <= request_kind;
        end
        w_reg <= w_next;
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (st_reg == ST_FIN && out_free)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_FIN && out_free)
        begin
            out_acc_reg   <= acc_reg && (mode_reg == MODE_ENQUEUE);
            out_floor_reg <= cur_reg[5:0];
            out_phase_reg <= phase_reg;
            out_dir_reg   <= head_reg;
            out_cnt_reg   <= 6'(len_reg);
        end
    end

    assign out_valid        = out_valid_reg;
    assign accepted         = out_acc_reg;
    assign car_floor        = out_floor_reg;
    assign motion_state     = out_phase_reg;
    assign travel_direction = out_dir_reg;
    assign queued_count     = out_cnt_reg;

    // Checks on the queue and result logic.
    `ESS_ASSERT_IMPL(a_len_bound, 1'b1, len_reg <= LW'(QUEUE_DEPTH))
    `ESS_ASSERT_NEXT(a_ins_grows, st_reg == ST_INS && !(found_reg && dup_reg),
        len_reg == $past(len_reg) + LW'(1))
    `ESS_ASSERT_NEXT(a_pop_shrinks, st_reg == ST_POP && head_here,
        len_reg == $past(len_reg) - LW'(1))
    `ESS_ASSERT_NEXT(a_fin_result, st_reg == ST_FIN && out_free,
        out_valid_reg && st_reg == ST_IDLE)

endmodule

// File: tb/sv/elevator_scan_scheduler_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Elevator scan scheduler testbench
// Drives tick and floor request words through the valid/ready handshake under
// several register settings, predicts each result word with an in-bench model
// of the scan scheduler or a fixed directed value, and compares whole words.
// ----------------------------------------------------------------------------
module elevator_scan_scheduler_tb;
    import ess_pkg::*;

    localparam int QDEPTH      = 32;
    localparam int FLOOR_LIMIT = 64;
    localparam int MOVE_CAP    = 4 * FLOOR_LIMIT + 8;
    localparam int STALL_LIMIT = 20000;
    localparam int RAND_ITEMS  = 190;
    localparam int NUM_SETS    = 6;

    typedef struct packed {
        logic       acc;
        logic [5:0] car;
        logic [1:0] ph;
        logic [1:0] dir;
        logic [5:0] count;
    } status_word_t;

    typedef struct packed {
        logic         md;
        logic [5:0]   flr;
        logic [1:0]   kind;
        logic         known;
        status_word_t want;
    } stim_row_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;
    logic       in_valid;
    logic       in_ready;
    logic       mode;
    logic [5:0] floor;
    logic [1:0] request_kind;
    logic       out_valid;
    logic       out_ready;
    logic       accepted;
    logic [5:0] car_floor;
    logic [1:0] motion_state;
    logic [1:0] travel_direction;
    logic [5:0] queued_count;

    // Scheduler state as predicted.
    int unsigned floors_cfg, stat_len, btwn_len, pass_len;
    logic [5:0]  stop_floor [QDEPTH];
    logic [1:0]  stop_kind [QDEPTH];
    int unsigned stops, car_at, car_dir, car_phase, phase_cnt;

    status_word_t pending_status[$];
    int           mismatches;
    int           words_sent;
    int           words_seen;
    int           stall_cycles;
    int           send_idle_pct;
    int           recv_idle_pct;

    elevator_scan_scheduler DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned floors_served();
        if (floors_cfg < 2) return 2;
        if (floors_cfg > FLOOR_LIMIT) return FLOOR_LIMIT;
        return floors_cfg;
    endfunction

    function automatic int unsigned direction_needed(int unsigned f, int unsigned k);
        if (k == KIND_UP) return DIR_UP;
        if (k == KIND_DOWN) return DIR_DN;
        if (f > car_at) return DIR_UP;
        if (f < car_at) return DIR_DN;
        return (car_dir == DIR_UP) ? DIR_DN : DIR_UP;
    endfunction

    // Twice the bounce-back travel distance, plus one for a drop-off.
    function automatic int unsigned stop_weight(int unsigned f, int unsigned k);
        int unsigned moves, want, top, sf, sd;
        moves = 0;
        if (f != car_at || car_phase != PH_STAT)
        begin
            want = direction_needed(f, k);
            top  = floors_served() - 1;
            sf   = car_at;
            if (car_dir == DIR_IDLE) sd = (f > car_at) ? DIR_UP : DIR_DN;
            else sd = car_dir;
            do
            begin
                moves++;
                if (sd == DIR_UP)
                begin
                    if (sf >= top) sd = DIR_DN;
                    else sf++;
                end
                else
                begin
                    if (sf == 0) sd = DIR_UP;
                    else sf--;
                end
            end while ((sd != want || sf != f) && moves < MOVE_CAP);
        end
        return moves * 2 + ((k == KIND_DROP) ? 1 : 0);
    endfunction

    function automatic void enter_phase(int unsigned p);
        car_phase = p;
        phase_cnt = 0;
    endfunction

    function automatic void drop_head();
        for (int unsigned i = 1; i < stops; i++)
        begin
            stop_floor[i-1] = stop_floor[i];
            stop_kind[i-1]  = stop_kind[i];
        end
        stops--;
    endfunction

    function automatic bit insert_request(int unsigned f, int unsigned k);
        int unsigned w, lw, i;
        lw = 0;
        i  = 0;
        if (k > KIND_DROP || f >= floors_served() || stops >= QDEPTH) return 0;
        w = stop_weight(f, k);
        while (i < stops)
        begin
            lw = stop_weight(stop_floor[i], stop_kind[i]);
            if (w <= lw) break;
            i++;
        end
        if (i < stops && w == lw) return 0;
        for (int unsigned j = stops; j > i; j--)
        begin
            stop_floor[j] = stop_floor[j-1];
            stop_kind[j]  = stop_kind[j-1];
        end
        stop_floor[i] = 6'(f);
        stop_kind[i]  = 2'(k);
        stops++;
        return 1;
    endfunction

    // One tick of the stationary / between / passing timer.
    function automatic void advance_car();
        int unsigned len, top, nxt;
        if (car_phase == PH_BETWEEN) len = btwn_len;
        else if (car_phase == PH_PASSING) len = pass_len;
        else len = stat_len;
        if (phase_cnt == len)
        begin
            if (car_phase == PH_BETWEEN)
            begin
                top = floors_served() - 1;
                if (stops == 0 || (car_dir != DIR_UP && car_dir != DIR_DN) ||
                    (car_dir == DIR_DN && car_at == 0) ||
                    (car_dir == DIR_UP && car_at >= top))
                    enter_phase(PH_STAT);
                else
                begin
                    nxt = (car_dir == DIR_UP) ? car_at + 1 : car_at - 1;
                    enter_phase((stop_floor[0] == nxt) ? PH_STAT : PH_PASSING);
                    car_at = nxt;
                end
            end
            else if (car_phase == PH_PASSING)
                enter_phase(PH_BETWEEN);
            else if (stops == 0)
            begin
                enter_phase(PH_STAT);
                car_dir = DIR_IDLE;
            end
            else if (stop_floor[0] == car_at)
            begin
                while (stops > 0 && stop_floor[0] == car_at) drop_head();
                enter_phase(PH_STAT);
            end
            else
            begin
                car_dir = (stop_floor[0] > car_at) ? DIR_UP : DIR_DN;
                enter_phase(PH_BETWEEN);
            end
        end
        phase_cnt = (phase_cnt + 1) & 8'hFF;
    endfunction

    function automatic status_word_t schedule_word(logic md, logic [5:0] f, logic [1:0] k);
        status_word_t s;
        s.acc = 1'b0;
        if (md == MODE_ENQUEUE) s.acc = insert_request(f, k);
        else advance_car();
        s.car   = car_at[5:0];
        s.ph    = car_phase[1:0];
        s.dir   = car_dir[1:0];
        s.count = stops[5:0];
        return s;
    endfunction

    // Offer one word and hold it until the block takes it.
    task automatic send_word(logic md, logic [5:0] f, logic [1:0] k,
                             logic known, status_word_t want);
        status_word_t s;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid     = 1'b1;
        mode         = md;
        floor        = f;
        request_kind = k;
        do @(posedge clk); while (!in_ready);
        s = schedule_word(md, f, k);
        pending_status.push_back(known ? want : s);
        words_sent++;
        if (words_sent == 400)
        begin
            send_idle_pct = 47;
            recv_idle_pct = 26;
        end
        else if (words_sent == 800)
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        @(negedge clk);
    endtask

    // Registers change only with the block drained and idle.
    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        in_valid = 1'b0;
        wait (pending_status.size() == 0);
        repeat (QDEPTH + 8) @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        case (idx)
            CFG_FLOOR_COUNT: floors_cfg = val & 8'h7F;
            CFG_STAT_TICKS:  stat_len = val;
            CFG_BTWN_TICKS:  btwn_len = val;
            default:         pass_len = val;
        endcase
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // Receiver stalls at random.
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Compare each taken result word with the oldest prediction.
    always @(posedge clk)
    begin
        status_word_t got, exp_w;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{accepted, car_floor, motion_state, travel_direction, queued_count};
            words_seen++;
            if (pending_status.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result word %p", got);
            end
            else
            begin
                exp_w = pending_status.pop_front();
                if (got != exp_w)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: word %0d expected %p got %p",
                                 words_seen, exp_w, got);
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either side.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Timeout with %0d words outstanding", pending_status.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        stim_row_t    rows[$];
        status_word_t idle0;
        status_word_t none_w;
        int           set_floors[NUM_SETS] = '{64, 2, 127, 5, 0, 40};
        int           set_stat[NUM_SETS]   = '{1, 255, 2, 1, 0, 3};
        int           set_btwn[NUM_SETS]   = '{1, 1, 3, 2, 0, 1};
        int           set_pass[NUM_SETS]   = '{1, 255, 1, 1, 0, 2};
        int unsigned  nf;
        logic [5:0]   f;
        logic [1:0]   k;
        logic         md;

        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_FLOOR_COUNT;
        cfg_data = '0;
        in_valid = 1'b0;
        mode = MODE_TICK;
        floor = '0;
        request_kind = KIND_UP;
        out_ready = 1'b0;
        mismatches = 0;
        words_sent = 0;
        words_seen = 0;
        stall_cycles = 0;
        send_idle_pct = 26;
        recv_idle_pct = 47;
        floors_cfg = 16;
        stat_len = 4;
        btwn_len = 4;
        pass_len = 2;
        stops = 0;
        car_at = 0;
        car_dir = DIR_IDLE;
        car_phase = PH_STAT;
        phase_cnt = 0;
        idle0 = '{1'b0, 6'd0, PH_STAT, DIR_IDLE, 6'd0};
        none_w = '0;

        // Directed words: reset state, rejected requests, then a short trip.
        rows.push_back('{MODE_TICK, 6'd0, KIND_UP, 1'b1, idle0});
        rows.push_back('{MODE_ENQUEUE, 6'd0, 2'd3, 1'b1, idle0});
        rows.push_back('{MODE_ENQUEUE, 6'd16, KIND_UP, 1'b1, idle0});
        rows.push_back('{MODE_ENQUEUE, 6'd63, KIND_DROP, 1'b1, idle0});
        rows.push_back('{MODE_ENQUEUE, 6'd0, KIND_DROP, 1'b1,
                         '{1'b1, 6'd0, PH_STAT, DIR_IDLE, 6'd1}});
        rows.push_back('{MODE_ENQUEUE, 6'd15, KIND_UP, 1'b0, none_w});
        rows.push_back('{MODE_ENQUEUE, 6'd15, KIND_DOWN, 1'b0, none_w});
        rows.push_back('{MODE_ENQUEUE, 6'd15, KIND_UP, 1'b0, none_w});
        rows.push_back('{MODE_ENQUEUE, 6'd7, KIND_DROP, 1'b0, none_w});
        rows.push_back('{MODE_ENQUEUE, 6'd0, KIND_UP, 1'b0, none_w});
        for (int i = 0; i < 14; i++)
            rows.push_back('{MODE_TICK, 6'd0, KIND_UP, 1'b0, none_w});
        rows.push_back('{MODE_ENQUEUE, 6'd42, 2'd3, 1'b0, none_w});

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[i])
            send_word(rows[i].md, rows[i].flr, rows[i].kind, rows[i].known, rows[i].want);

        // Random traffic under each register setting.
        for (int s = 0; s < NUM_SETS; s++)
        begin
            write_reg(CFG_FLOOR_COUNT, 8'(set_floors[s]));
            write_reg(CFG_STAT_TICKS, 8'(set_stat[s]));
            write_reg(CFG_BTWN_TICKS, 8'(set_btwn[s]));
            write_reg(CFG_PASS_TICKS, 8'(set_pass[s]));
            nf = floors_served();
            for (int n = 0; n < RAND_ITEMS; n++)
            begin
                // The first setting opens with a burst of 45 enqueue words.
                md = (s == 0 && n < 45) ? MODE_ENQUEUE :
                     (($urandom_range(99) < 35) ? MODE_ENQUEUE : MODE_TICK);
                f  = ($urandom_range(9) == 0) ? 6'($urandom_range(63))
                                              : 6'($urandom_range(nf - 1));
                k  = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
                send_word(md, f, k, 1'b0, none_w);
            end
        end

        in_valid = 1'b0;
        wait (pending_status.size() == 0);
        repeat (QDEPTH + 8) @(posedge clk);

        $display("Sent %0d words (ticks and floor requests) over %0d register settings,",
                 words_sent, NUM_SETS + 1);
        $display("checked %0d result words, %0d mismatches.", words_seen, mismatches);
        if (mismatches == 0 && pending_status.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ess_pkg.sv
rtl/ess_cell.sv
rtl/ess_weight.sv
rtl/elevator_scan_scheduler.sv
tb/sv/elevator_scan_scheduler_tb.sv
